// ===== design/pcsed_pkg.sv =====
// Package for the point cloud step edge detector.
// Holds payload structs, command codes, config register indexes and sequencer states.
package pcsed_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_CROP_HALF = 3'd3,
    REG_DZ_THR    = 3'd4,
    REG_MIN_RANGE = 3'd5,
    REG_NBR_COUNT = 3'd6,
    REG_POS_KNOWN = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic               point_valid;
    logic [11:0]        query_index;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               is_edge;
    logic               index_ok;
    logic [12:0]        stored_count;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic [14:0]        crop_half;
    logic [14:0]        dz_threshold;
    logic [14:0]        min_range;
    logic [3:0]         neighbor_count;
    logic               position_known;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QRD,
    ST_QLAT,
    ST_SCAN,
    ST_FINAL,
    ST_OUT
  } state_e;

endpackage

// ===== design/pcsed_store.sv =====
// Point store memory: one write port, one registered read port.
// Depends on pcsed_pkg for nothing beyond widths given by parameters.
module pcsed_store #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [47:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [47:0]      rdata_o
);
  logic [47:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== design/pcsed_knn.sv =====
// Sorted list of the k best distances with insertion and tie to lower index.
// Depends on pcsed_pkg; flags whether any kept neighbor has a large height step.
module pcsed_knn #(
  parameter int unsigned MaxNbr = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clr_i,
  input  logic        ins_i,
  input  logic [4:0]  k_i,
  input  logic [34:0] dist_i,
  input  logic        big_i,
  output logic        any_big_o
);
  import pcsed_pkg::*;

  logic [34:0] bd_q [MaxNbr];
  logic        bb_q [MaxNbr];
  logic        vl_q [MaxNbr];
  logic [34:0] bd_d [MaxNbr];
  logic        bb_d [MaxNbr];
  logic        vl_d [MaxNbr];
  logic        lt   [MaxNbr];

  always_comb begin
    for (int i = 0; i < MaxNbr; i++) begin
      lt[i] = !vl_q[i] || (dist_i < bd_q[i]);
    end
    for (int i = 0; i < MaxNbr; i++) begin
      bd_d[i] = bd_q[i];
      bb_d[i] = bb_q[i];
      vl_d[i] = vl_q[i];
      if (ins_i && (i < int'(k_i))) begin
        if (lt[i]) begin
          if (i == 0 || !lt[(i == 0) ? 0 : i-1]) begin
            bd_d[i] = dist_i;
            bb_d[i] = big_i;
            vl_d[i] = 1'b1;
          end else begin
            bd_d[i] = bd_q[(i == 0) ? 0 : i-1];
            bb_d[i] = bb_q[(i == 0) ? 0 : i-1];
            vl_d[i] = vl_q[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxNbr; i++) vl_q[i] <= 1'b0;
    end else if (clr_i) begin
      for (int i = 0; i < MaxNbr; i++) vl_q[i] <= 1'b0;
    end else begin
      for (int i = 0; i < MaxNbr; i++) vl_q[i] <= vl_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxNbr; i++) begin
      bd_q[i] <= bd_d[i];
      bb_q[i] <= bb_d[i];
    end
  end

  always_comb begin
    any_big_o = 1'b0;
    for (int i = 0; i < MaxNbr; i++) begin
      any_big_o = any_big_o | (vl_q[i] & bb_q[i]);
    end
  end
endmodule

// ===== design/point_cloud_step_edge_detector.sv =====
// Step edge detector top: command sequencer, config, store and k-NN list.
// A query reads the query point, scans the store, then finalizes; a rejected index goes straight to output.
// Throughput: one word at a time; a query scans the store one entry a cycle.
// Reset clears count and control and sets config to its defaults; store contents stay undefined.
// Depends on pcsed_pkg, pcsed_store, pcsed_knn.
module point_cloud_step_edge_detector #(
  parameter int unsigned MAX_POINTS    = 4096,
  parameter int unsigned MAX_NEIGHBORS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pcsed_pkg::in_word_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pcsed_pkg::out_word_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [pcsed_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pcsed_pkg::CfgDataW-1:0]      cfg_data_i
);
  import pcsed_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_POINTS);
  localparam int unsigned CntW  = AddrW + 1;
  localparam int unsigned KW    = $clog2(MAX_NEIGHBORS + 1);

  cfg_t cfg_q;
  state_e st_q, st_d;
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  scan_q;
  logic [AddrW-1:0] qi_q;
  logic signed [15:0] qx_q, qy_q, qz_q;
  logic             ok_q;
  logic             pend_q;
  logic             vld_q;
  out_word_t        out_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{center_x: '0, center_y: '0, center_z: '0, crop_half: 15'd20000,
                 dz_threshold: 15'd100, min_range: 15'd1000,
                 neighbor_count: 4'd5, position_known: 1'b0};
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CENTER_X:  cfg_q.center_x <= cfg_data_i;
        REG_CENTER_Y:  cfg_q.center_y <= cfg_data_i;
        REG_CENTER_Z:  cfg_q.center_z <= cfg_data_i;
        REG_CROP_HALF: cfg_q.crop_half <= cfg_data_i[14:0];
        REG_DZ_THR:    cfg_q.dz_threshold <= cfg_data_i[14:0];
        REG_MIN_RANGE: cfg_q.min_range <= cfg_data_i[14:0];
        REG_NBR_COUNT: cfg_q.neighbor_count <= cfg_data_i[3:0];
        REG_POS_KNOWN: cfg_q.position_known <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // crop test
  function automatic logic in_box(logic signed [15:0] p, logic signed [15:0] c,
                                  logic [14:0] h);
    logic signed [17:0] lo, hi;
    lo = 18'(c) - 18'(signed'({3'b0, h}));
    hi = 18'(c) + 18'(signed'({3'b0, h}));
    return (18'(p) >= lo) && (18'(p) <= hi);
  endfunction

  logic acc;
  logic is_load, keep;
  assign acc = in_valid_i && in_ready_o;
  assign is_load = cmd_e'(in_data_i.cmd) == CMD_LOAD;
  assign keep = in_data_i.point_valid && in_box(in_data_i.px, cfg_q.center_x, cfg_q.crop_half)
             && in_box(in_data_i.py, cfg_q.center_y, cfg_q.crop_half)
             && in_box(in_data_i.pz, cfg_q.center_z, cfg_q.crop_half)
             && (cnt_q < CntW'(MAX_POINTS));

  // memory
  logic             we;
  logic [AddrW-1:0] raddr;
  logic [47:0]      rdata;
  assign we = acc && is_load && keep;

  pcsed_store #(.Depth(MAX_POINTS), .AddrW(AddrW)) u_store (
    .clk_i, .we_i(we), .waddr_i(cnt_q[AddrW-1:0]),
    .wdata_i({in_data_i.px, in_data_i.py, in_data_i.pz}),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic signed [15:0] rx, ry, rz;
  assign rx = rdata[47:32];
  assign ry = rdata[31:16];
  assign rz = rdata[15:0];

  // distance pipe: diff -> square -> sum
  logic signed [16:0] dx, dy, dz;
  logic [33:0] s0_q, s1_q, s2_q;
  logic [16:0] adz;
  logic        big_s_q, big_q;
  logic        v1_q, v2_q;
  logic [34:0] dist_q;
  assign dx = 17'(rx) - 17'(qx_q);
  assign dy = 17'(ry) - 17'(qy_q);
  assign dz = 17'(rz) - 17'(qz_q);
  assign adz = dz[16] ? 17'(-dz) : 17'(dz);

  // range check
  logic [33:0] r0_q, r1_q, r2_q;
  logic        far;
  assign far = (36'(r0_q) + 36'(r1_q) + 36'(r2_q)) >
               36'(30'(cfg_q.min_range) * 30'(cfg_q.min_range));

  logic [KW-1:0] kcl;
  always_comb begin
    if (cfg_q.neighbor_count == 4'd0) kcl = KW'(1);
    else if (32'(cfg_q.neighbor_count) > MAX_NEIGHBORS) kcl = KW'(MAX_NEIGHBORS);
    else kcl = KW'(cfg_q.neighbor_count);
  end

  logic any_big;
  logic scan_rd;
  assign scan_rd = (st_q == ST_SCAN) && (scan_q < cnt_q);

  pcsed_knn #(.MaxNbr(MAX_NEIGHBORS)) u_knn (
    .clk_i, .rst_ni, .clr_i(st_q == ST_QLAT), .ins_i(v2_q),
    .k_i(5'(kcl)), .dist_i(dist_q), .big_i(big_q), .any_big_o(any_big)
  );

  always_comb begin
    raddr = scan_rd ? scan_q[AddrW-1:0] : qi_q;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (acc && cmd_e'(in_data_i.cmd) == CMD_QUERY) st_d = ST_QRD;
      ST_QRD:  st_d = ok_q ? ST_QLAT : ST_OUT;
      ST_QLAT: st_d = ST_SCAN;
      ST_SCAN: if (!scan_rd && !pend_q && !v1_q && !v2_q) st_d = ST_FINAL;
      ST_FINAL: st_d = ST_OUT;
      ST_OUT:  if (!vld_q) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (st_q == ST_IDLE) && !vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cnt_q <= '0; scan_q <= '0; ok_q <= 1'b0;
      pend_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      pend_q <= scan_rd;
      v1_q <= pend_q;
      v2_q <= v1_q;
      if (acc) begin
        case (cmd_e'(in_data_i.cmd))
          CMD_LOAD:  if (keep) cnt_q <= cnt_q + CntW'(1);
          CMD_CLEAR: cnt_q <= '0;
          CMD_QUERY: ok_q <= cfg_q.position_known &&
                             (CntW'(in_data_i.query_index) < cnt_q) &&
                             (32'(in_data_i.query_index) < MAX_POINTS);
          default: ;
        endcase
      end
      if (st_q == ST_QLAT) scan_q <= '0;
      else if (scan_rd) scan_q <= scan_q + CntW'(1);
      if (out_valid_o && out_ready_i) vld_q <= 1'b0;
      else if (st_q == ST_OUT && !vld_q) vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) qi_q <= AddrW'(in_data_i.query_index);
    if (st_q == ST_QLAT) begin
      qx_q <= rx; qy_q <= ry; qz_q <= rz;
      r0_q <= 34'(rx * rx); r1_q <= 34'(ry * ry); r2_q <= 34'(rz * rz);
    end
    s0_q <= 34'(dx * dx);
    s1_q <= 34'(dy * dy);
    s2_q <= 34'(dz * dz);
    big_s_q <= adz > 17'(cfg_q.dz_threshold);
    dist_q <= 35'(s0_q) + 35'(s1_q) + 35'(s2_q);
    big_q <= big_s_q;
    if (st_q == ST_QRD && !ok_q) begin
      out_q <= '{out_x: '0, out_y: '0, out_z: '0, is_edge: 1'b0, index_ok: 1'b0,
                 stored_count: 13'(cnt_q)};
    end else if (st_q == ST_FINAL) begin
      out_q <= '{out_x: qx_q, out_y: qy_q, out_z: qz_q, is_edge: far && any_big,
                 index_ok: 1'b1, stored_count: 13'(cnt_q)};
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;
endmodule
